[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/swec_pkg.sv]
// ---------------------------------------------------------------------------
// swec_pkg
// Types and constants shared by the sliding window event counter.
// ---------------------------------------------------------------------------
package swec_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 32;
    localparam int TERM_W     = 16;
    localparam int WIN_W      = 7;
    localparam int SPAN_W     = TERM_W + WIN_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Operation codes
    localparam logic OP_EVENT = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BUCKET_TERM    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_BUCKETS = 1'd1;

    localparam logic [TERM_W-1:0] BUCKET_TERM_RST    = 16'd1;
    localparam logic [WIN_W-1:0]  WINDOW_BUCKETS_RST = 7'd60;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef struct packed {
        logic [TIME_W-1:0]  base;
        logic [COUNT_W-1:0] events;
    } swec_entry_t;

    typedef struct packed {
        logic load;
        logic calc_base;
        logic calc_limit;
        logic rd_newest;
        logic rd_oldest;
        logic bump;
        logic drop;
        logic open;
        logic load_out;
    } swec_cmd_t;

    typedef struct packed {
        logic div_done;
        logic live_zero;
        logic live_full;
        logic same_base;
        logic expired;
        logic no_retire;
        logic op_query;
    } swec_status_t;

endpackage

[rtl/swec_if.sv]
// ---------------------------------------------------------------------------
// swec item and result channels
// Valid/ready channels carrying one input item and one result.
// ---------------------------------------------------------------------------
interface swec_item_if
    import swec_pkg::*;
();
    logic              valid;
    logic              ready;
    logic              op;
    logic [TIME_W-1:0] time_now;

    modport source (output valid, output op, output time_now, input ready);
    modport sink   (input valid, input op, input time_now, output ready);
endinterface

interface swec_result_if
    import swec_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] window_count;

    modport source (output valid, output window_count, input ready);
    modport sink   (input valid, input window_count, output ready);
endinterface

[rtl/swec_ram.sv]
// ---------------------------------------------------------------------------
// swec_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module swec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/swec_div.sv]
// ---------------------------------------------------------------------------
// swec_div
// Restoring remainder unit: one dividend bit per cycle.
// ---------------------------------------------------------------------------
module swec_div
    import swec_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [TIME_W-1:0] dividend,
    input  logic [TERM_W-1:0] divisor,
    output logic              done,
    output logic [TERM_W-1:0] rem
);

    localparam int STEP_W = $clog2(TIME_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [TIME_W-1:0] shift_reg;
    logic [TERM_W-1:0] div_reg;
    logic [TERM_W-1:0] rem_reg;
    logic [TERM_W:0]   trial;
    logic [TERM_W-1:0] rem_next;

    assign trial = {rem_reg, shift_reg[TIME_W-1]};

    always_comb
    begin
        if (trial >= {1'b0, div_reg})
        begin
            rem_next = TERM_W'(trial - {1'b0, div_reg});
        end
        else
        begin
            rem_next = trial[TERM_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(TIME_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= dividend;
            div_reg   <= divisor;
            rem_reg   <= '0;
        end
        else if (busy_reg)
        begin
            shift_reg <= {shift_reg[TIME_W-2:0], 1'b0};
            rem_reg   <= rem_next;
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

[rtl/swec_dp.sv]
// ---------------------------------------------------------------------------
// swec_dp
// Datapath: configuration, base time and window limit, bucket ring and total.
// ---------------------------------------------------------------------------
module swec_dp
    import swec_pkg::*;
#(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  op,
    input  logic [TIME_W-1:0]     time_now,
    input  swec_cmd_t             cmd,
    output swec_status_t          status,
    output logic [COUNT_W-1:0]    window_count
);

    localparam int IDX_W = $clog2(MAX_BUCKETS);
    localparam int CNT_W = $clog2(MAX_BUCKETS + 1);
    localparam int SUM_W = CNT_W + 1;

    function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(MAX_BUCKETS))
        begin
            s = s - SUM_W'(MAX_BUCKETS);
        end
        return s[IDX_W-1:0];
    endfunction

    logic [TERM_W-1:0]  bucket_term_reg;
    logic [WIN_W-1:0]   window_buckets_reg;
    logic               op_reg;
    logic [TIME_W-1:0]  time_reg;
    logic [SPAN_W-1:0]  span_reg;
    logic [TIME_W-1:0]  base_reg;
    logic [TIME_W-1:0]  limit_reg;
    logic               no_retire_reg;
    logic [IDX_W-1:0]   oldest_reg;
    logic [CNT_W-1:0]   live_reg;
    logic [COUNT_W-1:0] total_reg;
    logic [COUNT_W-1:0] window_count_reg;

    logic [TERM_W-1:0]  term_eff;
    logic               div_done;
    logic [TERM_W-1:0]  rem;
    logic [IDX_W-1:0]   newest_addr;
    logic [IDX_W-1:0]   new_addr;
    logic [IDX_W-1:0]   oldest_next;
    logic [CNT_W-1:0]   live_next;
    logic [COUNT_W-1:0] total_inc;
    logic [COUNT_W-1:0] total_sub;
    logic [COUNT_W-1:0] events_inc;
    swec_entry_t        rd_entry;
    swec_entry_t        wr_entry;
    logic [$bits(swec_entry_t)-1:0] rd_bits;
    logic [IDX_W-1:0]   raddr;
    logic [IDX_W-1:0]   waddr;

    // A zero term behaves as one
    assign term_eff = (bucket_term_reg == '0) ? TERM_W'(1) : bucket_term_reg;

    swec_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.load),
        .dividend (time_now),
        .divisor  (term_eff),
        .done     (div_done),
        .rem      (rem)
    );

    assign newest_addr = ring_add(oldest_reg, live_reg - CNT_W'(1));
    assign new_addr    = ring_add(oldest_reg, live_reg);
    assign live_next   = live_reg - CNT_W'(1);
    // An emptied ring restarts at position zero
    assign oldest_next = (live_next == '0) ? '0 : ring_add(oldest_reg, CNT_W'(1));

    assign rd_entry   = swec_entry_t'(rd_bits);
    assign total_inc  = (total_reg == COUNT_MAX) ? total_reg : total_reg + COUNT_W'(1);
    assign total_sub  = (total_reg >= rd_entry.events) ? total_reg - rd_entry.events : '0;
    assign events_inc = (rd_entry.events == COUNT_MAX) ? rd_entry.events
                                                       : rd_entry.events + COUNT_W'(1);

    assign raddr = cmd.rd_newest ? newest_addr : oldest_reg;
    assign waddr = cmd.bump ? newest_addr : new_addr;

    always_comb
    begin
        wr_entry.base = base_reg;
        if (cmd.bump)
        begin
            wr_entry.events = events_inc;
        end
        else
        begin
            wr_entry.events = COUNT_W'(1);
        end
    end

    swec_ram #(
        .WIDTH ($bits(swec_entry_t)),
        .DEPTH (MAX_BUCKETS)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.bump | cmd.open),
        .waddr (waddr),
        .wdata (wr_entry),
        .re    (cmd.rd_newest | cmd.rd_oldest),
        .raddr (raddr),
        .rdata (rd_bits)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bucket_term_reg    <= BUCKET_TERM_RST;
            window_buckets_reg <= WINDOW_BUCKETS_RST;
            oldest_reg         <= '0;
            live_reg           <= '0;
            total_reg          <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                case (wr_index)
                    REG_BUCKET_TERM:    bucket_term_reg    <= wr_data[TERM_W-1:0];
                    REG_WINDOW_BUCKETS: window_buckets_reg <= wr_data[WIN_W-1:0];
                    default:            ;
                endcase
            end
            if (cmd.drop)
            begin
                total_reg  <= total_sub;
                live_reg   <= live_next;
                oldest_reg <= oldest_next;
            end
            else if (cmd.open)
            begin
                total_reg <= total_inc;
                live_reg  <= live_reg + CNT_W'(1);
            end
            else if (cmd.bump)
            begin
                total_reg <= total_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op;
            time_reg <= time_now;
            span_reg <= SPAN_W'(term_eff) * SPAN_W'(window_buckets_reg);
        end
        if (cmd.calc_base)
        begin
            base_reg <= time_reg - TIME_W'(rem);
        end
        if (cmd.calc_limit)
        begin
            no_retire_reg <= (TIME_W'(span_reg) > base_reg);
            limit_reg     <= base_reg - TIME_W'(span_reg);
        end
        if (cmd.load_out)
        begin
            window_count_reg <= total_reg;
        end
    end

    always_comb
    begin
        status.div_done  = div_done;
        status.live_zero = (live_reg == '0);
        status.live_full = (live_reg == CNT_W'(MAX_BUCKETS));
        status.same_base = (rd_entry.base == base_reg);
        status.expired   = (rd_entry.base <= limit_reg);
        status.no_retire = no_retire_reg;
        status.op_query  = (op_reg == OP_QUERY);
    end

    assign window_count = window_count_reg;

endmodule

[rtl/swec_ctrl.sv]
// ---------------------------------------------------------------------------
// swec_ctrl
// Controller: sequences remainder, bucket update, retirement and result.
// ---------------------------------------------------------------------------
module swec_ctrl
    import swec_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    output logic         result_valid,
    input  logic         result_ready,
    input  swec_status_t status,
    output swec_cmd_t    cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_LIMIT,
        S_NEW_RD,
        S_NEW_CMP,
        S_FULL_DROP,
        S_OPEN,
        S_RET_RD,
        S_RET_CMP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   out_free;

    assign out_free = !result_valid_reg || result_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    cmd.calc_base = 1'b1;
                    state_next    = S_LIMIT;
                end
            end
            S_LIMIT:
            begin
                cmd.calc_limit = 1'b1;
                if (status.op_query)
                begin
                    state_next = S_RET_RD;
                end
                else if (status.live_zero)
                begin
                    state_next = S_OPEN;
                end
                else
                begin
                    state_next = S_NEW_RD;
                end
            end
            S_NEW_RD:
            begin
                cmd.rd_newest = 1'b1;
                state_next    = S_NEW_CMP;
            end
            S_NEW_CMP:
            begin
                if (status.same_base)
                begin
                    cmd.bump   = 1'b1;
                    state_next = S_RET_RD;
                end
                else if (status.live_full)
                begin
                    // make room: the oldest bucket leaves first
                    cmd.rd_oldest = 1'b1;
                    state_next    = S_FULL_DROP;
                end
                else
                begin
                    cmd.open   = 1'b1;
                    state_next = S_RET_RD;
                end
            end
            S_FULL_DROP:
            begin
                cmd.drop   = 1'b1;
                state_next = S_OPEN;
            end
            S_OPEN:
            begin
                cmd.open   = 1'b1;
                state_next = S_RET_RD;
            end
            S_RET_RD:
            begin
                if (status.no_retire || status.live_zero)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_oldest = 1'b1;
                    state_next    = S_RET_CMP;
                end
            end
            S_RET_CMP:
            begin
                if (status.expired)
                begin
                    cmd.drop   = 1'b1;
                    state_next = S_RET_RD;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign item_ready   = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;

endmodule

[rtl/sliding_window_event_counter_core.sv]
// ---------------------------------------------------------------------------
// sliding_window_event_counter_core
// Counts events over a sliding window of time buckets.
// ---------------------------------------------------------------------------
// Each item (event or query, with a time in seconds) gives one result: the
// saturating count of events still inside the window. Each item runs the
// 32-step remainder unit that aligns the time to the bucket term; an event
// then bumps or opens the newest bucket, dropping the oldest bucket first
// when it opens one on a full ring, and buckets are retired from the oldest
// end. Buckets live in one RAM of MAX_BUCKETS entries; a new item is taken
// while the previous result still waits in the output register.
module sliding_window_event_counter_core
    import swec_pkg::*;
#(
    parameter int MAX_BUCKETS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    swec_item_if.sink             item,
    swec_result_if.source         result
);

    swec_cmd_t    cmd;
    swec_status_t status;

    swec_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_ready   (item.ready),
        .result_valid (result.valid),
        .result_ready (result.ready),
        .status       (status),
        .cmd          (cmd)
    );

    swec_dp #(
        .MAX_BUCKETS (MAX_BUCKETS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .op           (item.op),
        .time_now     (item.time_now),
        .cmd          (cmd),
        .status       (status),
        .window_count (result.window_count)
    );

endmodule

[rtl/swec_chk.sv]
// ---------------------------------------------------------------------------
// swec_chk
// Port-level checks on the event counter's channels, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module swec_chk
    import swec_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               item_valid,
    input logic               item_ready,
    input logic               result_valid,
    input logic               result_ready,
    input logic [COUNT_W-1:0] result_window_count
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pending_reg;

    assign in_acc  = item_valid && item_ready;
    assign out_acc = result_valid && result_ready;

    // transactions taken in but not yet answered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 2'(in_acc) - 2'(out_acc);
        end
    end

    `ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid, "result dropped while stalled")
    `ASSERT_NEXT(a_count_hold, clk, rst_n, result_valid && !result_ready, $stable(result_window_count), "result changed while stalled")
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, !item_ready, "second item taken during work")
    `ASSERT_NOW(a_no_spurious, clk, rst_n, result_valid, pending_reg != 2'd0, "result without an item")
    `ASSERT_NOW(a_depth, clk, rst_n, in_acc, pending_reg != 2'd2, "more than two items in flight")

endmodule

bind sliding_window_event_counter_core swec_chk u_swec_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_valid          (item.valid),
    .item_ready          (item.ready),
    .result_valid        (result.valid),
    .result_ready        (result.ready),
    .result_window_count (result.window_count)
);
